/* rtl/ptl_pkg.sv */
package ptl_pkg;

    // Trie geometry
    localparam int NODE_COUNT = 4096;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int FREE_W     = IDX_W + 1;
    localparam int ID_W       = 16;
    localparam int ADDR_BITS  = 32;
    localparam int PLEN_W     = 6;
    localparam int LEVEL_W    = 6;
    localparam int OP_W       = 2;

    // Operation codes carried in the input tuser
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // One trie node: a child index of zero means no child
    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic [ID_W-1:0]  id;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    // Controller to datapath
    typedef struct packed {
        logic               start;
        logic               step;
        logic               out_load;
        logic [LEVEL_W-1:0] level;
    } ptl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic done;
        logic out_free;
    } ptl_stat_t;

endpackage

/* rtl/ptl_ram.sv */
module ptl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ptl_datapath.sv */
module ptl_datapath
    import ptl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ptl_cmd_t         cmd,
    output ptl_stat_t        stat,
    input  logic [55:0]      s_axis_tdata,
    input  logic [OP_W-1:0]  s_axis_tuser,
    input  logic             cfg_wr_en,
    input  logic [ID_W-1:0]  cfg_wr_data,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [ID_W-1:0]  m_axis_tdata,
    output logic             m_axis_tuser
);

    // Item fields
    logic [ADDR_BITS-1:0] in_address;
    logic [PLEN_W-1:0]    in_plen;
    logic [ID_W-1:0]      in_id;

    assign in_address = s_axis_tdata[31:0];
    assign in_plen    = s_axis_tdata[37:32];
    assign in_id      = s_axis_tdata[53:38];

    // Walk registers
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [PLEN_W-1:0]    plen_reg, plen_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    node_t                cur_node_reg, cur_node_next;
    logic                 from_ram_reg, from_ram_next;
    logic                 dirty_reg, dirty_next;
    logic                 have_reg, have_next;
    logic [ID_W-1:0]      best_reg, best_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;
    logic                 res_status_reg, res_status_next;

    // Trie bookkeeping and configuration
    logic [FREE_W-1:0]    next_free_reg, next_free_next;
    logic                 root_valid_reg, root_valid_next;
    logic [ID_W-1:0]      unknown_id_reg;

    // Output register
    logic                 out_valid_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic                 out_status_reg;

    // Node memory port
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    node_t                mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;
    logic [NODE_W-1:0]    mem_rdata;

    // Step evaluation
    node_t                ram_node;
    node_t                node_now;
    node_t                node_link;
    logic                 bit_sel;
    logic [IDX_W-1:0]     child;
    logic                 tree_full;
    logic                 is_leaf;
    logic                 at_plen;
    logic                 at_end;
    logic [ID_W-1:0]      fallback_id;
    logic                 step_done;

    ptl_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Root reads as empty until written since the last clear
    assign ram_node  = (cur_reg == '0 && !root_valid_reg) ? '0 : node_t'(mem_rdata);
    assign node_now  = from_ram_reg ? ram_node : cur_node_reg;
    assign bit_sel   = addr_reg[ADDR_BITS-1];
    assign child     = bit_sel ? node_now.right : node_now.left;
    assign tree_full = next_free_reg >= FREE_W'(NODE_COUNT);
    assign is_leaf   = (node_now.left == '0) && (node_now.right == '0);
    assign at_plen   = cmd.level == plen_reg;
    assign at_end    = cmd.level == LEVEL_W'(ADDR_BITS);

    // Best match so far including the current node
    always_comb
    begin
        if (node_now.id != '0)
        begin
            fallback_id = node_now.id;
        end
        else if (have_reg)
        begin
            fallback_id = best_reg;
        end
        else
        begin
            fallback_id = unknown_id_reg;
        end
    end

    // Link a freshly allocated child into the current node
    always_comb
    begin
        node_link = node_now;
        if (bit_sel)
        begin
            node_link.right = next_free_reg[IDX_W-1:0];
        end
        else
        begin
            node_link.left = next_free_reg[IDX_W-1:0];
        end
    end

    // Walk one trie level per cycle
    always_comb
    begin
        addr_next       = addr_reg;
        plen_next       = plen_reg;
        id_next         = id_reg;
        op_next         = op_reg;
        cur_next        = cur_reg;
        cur_node_next   = cur_node_reg;
        from_ram_next   = from_ram_reg;
        dirty_next      = dirty_reg;
        have_next       = have_reg;
        best_next       = best_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        next_free_next  = next_free_reg;
        root_valid_next = root_valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur_reg;
        mem_wdata       = node_now;
        mem_raddr       = '0;
        step_done       = 1'b0;

        if (cmd.start)
        begin
            // Load the item and fetch the root
            addr_next       = in_address;
            plen_next       = (in_plen > PLEN_W'(ADDR_BITS)) ? PLEN_W'(ADDR_BITS) : in_plen;
            id_next         = in_id;
            op_next         = s_axis_tuser;
            cur_next        = '0;
            from_ram_next   = 1'b1;
            dirty_next      = 1'b0;
            have_next       = 1'b0;
            best_next       = '0;
            res_id_next     = '0;
            res_status_next = 1'b0;
            mem_raddr       = '0;
            if (s_axis_tuser == OP_CLEAR)
            begin
                root_valid_next = 1'b0;
                next_free_next  = FREE_W'(1);
            end
        end
        else if (cmd.step)
        begin
            if (op_reg == OP_INSERT)
            begin
                if (at_plen)
                begin
                    // Store the id in the prefix node
                    mem_we          = 1'b1;
                    mem_wdata.id    = id_reg;
                    res_id_next     = '0;
                    res_status_next = 1'b0;
                    step_done       = 1'b1;
                end
                else if (child != '0)
                begin
                    // Follow an existing child
                    mem_raddr     = child;
                    cur_next      = child;
                    from_ram_next = 1'b1;
                    dirty_next    = 1'b0;
                    addr_next     = {addr_reg[ADDR_BITS-2:0], 1'b0};
                end
                else if (tree_full)
                begin
                    // Out of nodes: flush a pending new node, then stop
                    mem_we          = dirty_reg;
                    res_id_next     = '0;
                    res_status_next = 1'b1;
                    step_done       = 1'b1;
                end
                else
                begin
                    // Allocate a child, write back the parent with its link
                    mem_we         = 1'b1;
                    mem_wdata      = node_link;
                    cur_next       = next_free_reg[IDX_W-1:0];
                    cur_node_next  = '0;
                    from_ram_next  = 1'b0;
                    dirty_next     = 1'b1;
                    next_free_next = next_free_reg + FREE_W'(1);
                    addr_next      = {addr_reg[ADDR_BITS-2:0], 1'b0};
                end
            end
            else
            begin
                if (cmd.level != '0 && is_leaf)
                begin
                    // Stepped onto a leaf: answer its id
                    res_id_next     = node_now.id;
                    res_status_next = 1'b0;
                    step_done       = 1'b1;
                end
                else if (at_end)
                begin
                    res_id_next     = have_reg ? best_reg : unknown_id_reg;
                    res_status_next = 1'b0;
                    step_done       = 1'b1;
                end
                else if (child == '0)
                begin
                    res_id_next     = fallback_id;
                    res_status_next = 1'b0;
                    step_done       = 1'b1;
                end
                else
                begin
                    if (node_now.id != '0)
                    begin
                        have_next = 1'b1;
                        best_next = node_now.id;
                    end
                    mem_raddr = child;
                    cur_next  = child;
                    addr_next = {addr_reg[ADDR_BITS-2:0], 1'b0};
                end
            end
        end

        if (mem_we && mem_waddr == '0)
        begin
            root_valid_next = 1'b1;
        end
    end

    assign stat = '{done: step_done, out_free: !out_valid_reg || m_axis_tready};

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg  <= FREE_W'(1);
            root_valid_reg <= 1'b0;
            unknown_id_reg <= '0;
            out_valid_reg  <= 1'b0;
            from_ram_reg   <= 1'b1;
            dirty_reg      <= 1'b0;
            have_reg       <= 1'b0;
        end
        else
        begin
            next_free_reg  <= next_free_next;
            root_valid_reg <= root_valid_next;
            from_ram_reg   <= from_ram_next;
            dirty_reg      <= dirty_next;
            have_reg       <= have_next;
            if (cfg_wr_en)
            begin
                unknown_id_reg <= cfg_wr_data;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        plen_reg       <= plen_next;
        id_reg         <= id_next;
        op_reg         <= op_next;
        cur_reg        <= cur_next;
        cur_node_reg   <= cur_node_next;
        best_reg       <= best_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        if (cmd.out_load)
        begin
            out_id_reg     <= res_id_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_id_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

/* rtl/ptl_ctrl.sv */
module ptl_ctrl
    import ptl_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [OP_W-1:0] s_axis_tuser,
    output ptl_cmd_t        cmd,
    input  ptl_stat_t       stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               accept;

    assign s_axis_tready = state_reg == ST_IDLE;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Sequence: take an item, walk the levels, hand over the result
    always_comb
    begin
        state_next   = state_reg;
        level_next   = level_reg;
        cmd.start    = 1'b0;
        cmd.step     = 1'b0;
        cmd.out_load = 1'b0;
        cmd.level    = level_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.start  = 1'b1;
                    level_next = '0;
                    if (s_axis_tuser inside {OP_INSERT, OP_LOOKUP})
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (stat.done)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    level_next = level_reg + LEVEL_W'(1);
                end
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            level_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
        end
    end

endmodule

/* rtl/ipv4_prefix_trie_lookup.sv */
// IPv4 longest-prefix-match over a binary trie held in a 4096-node memory.
// Input items arrive on s_axis: tuser carries the operation (insert, lookup,
// clear), tdata the address, prefix length and entry id. Each item yields
// exactly one result item on m_axis: tdata is the matched id (zero for insert
// and clear), tuser is the status flag (set when an insert ran out of nodes).
// cfg_wr_en/cfg_wr_data set the id returned when a lookup matches nothing;
// write it only while no item is in flight.
// One trie level is walked per cycle, bounded by the single read port of the
// node memory. One item is in work at a time; the next is accepted once the
// result has moved to the output register.
// Reset empties the trie (root cleared, allocator back to node 1) and sets
// the unknown id to zero. If the receiver stalls, the result is held in the
// output register, one further item may be accepted and walked, and its result
// then waits until the output register is free.
module ipv4_prefix_trie_lookup
    import ptl_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // [31:0] address, [37:32] prefix_len, [53:38] entry_id, [55:54] zero
    input  logic [55:0]     s_axis_tdata,
    // [1:0] operation
    input  logic [OP_W-1:0] s_axis_tuser,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // [15:0] match_id
    output logic [ID_W-1:0] m_axis_tdata,
    // [0] status
    output logic            m_axis_tuser,
    input  logic            cfg_wr_en,
    input  logic [ID_W-1:0] cfg_wr_data
);

    ptl_cmd_t  cmd;
    ptl_stat_t stat;

    ptl_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .cmd           (cmd),
        .stat          (stat)
    );

    ptl_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
